// File: hw/rtl/ksfc_pkg.sv
// shared types and constants of the keyed s-box feistel cipher
`default_nettype none
package ksfc_pkg;
  localparam int unsigned TBL_DEPTH = 1024;
  localparam int unsigned TBL_AW    = 10;
  localparam int unsigned RK_DEPTH  = 16;
  localparam int unsigned RK_AW     = 4;

  typedef enum logic [1:0] {
    OP_REKEY   = 2'd0,
    OP_ENCRYPT = 2'd1,
    OP_DECRYPT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_KEY_HIGH    = 3'd0,
    REG_KEY_LOW     = 3'd1,
    REG_IV_HIGH     = 3'd2,
    REG_IV_LOW      = 3'd3,
    REG_ROUND_COUNT = 3'd4
  } reg_idx_t;
endpackage
`default_nettype wire

// File: hw/rtl/ksfc_if.sv
// valid/ready channel interfaces for input, result and configuration
`default_nettype none
interface ksfc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] left_in;
  logic [31:0] right_in;
  modport source (output valid, op, left_in, right_in, input ready);
  modport sink   (input valid, op, left_in, right_in, output ready);
endinterface

interface ksfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_out;
  logic [31:0] right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface ksfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/keyed_sbox_feistel_cipher_unit.sv
// keyed s-box feistel cipher top level: table memory, round keys, sequencer
//
// channel  dir  payload
// in_*     in   op, left_in, right_in
// out_*    out  left_out, right_out
// cfg_*    in   index, data (write only)
//
// a rekey does an identity fill of the 1024-entry table, then one swap per entry
// (read i, read j, write i, write j) on the single table port.
// a cipher item makes nine dependent s-box reads per round through the one table port;
// zero rounds or the unused op answer directly from idle.
// after reset the table is swept to zero before the first item is taken.
// a waiting result word holds off the next item; configuration is taken whenever idle.
`default_nettype none
module keyed_sbox_feistel_cipher_unit #(
  parameter int unsigned MAX_ROUNDS = 16,
  parameter int unsigned IV_BYTES   = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ksfc_in_if.sink   in_ch,
  ksfc_out_if.source out_ch,
  ksfc_cfg_if.sink  cfg_ch
);
  import ksfc_pkg::*;

  typedef enum logic [8:0] {
    ST_CLR   = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_INIT  = 9'b000000100,
    ST_SWRI  = 9'b000001000,
    ST_SWRJ  = 9'b000010000,
    ST_SWWI  = 9'b000100000,
    ST_SWWJ  = 9'b001000000,
    ST_RND   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  localparam int unsigned IV_WORDS = (IV_BYTES / 4 < 4) ? IV_BYTES / 4 : 4;

  state_t state_r;
  logic [63:0] key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic [4:0]  round_count_r;
  logic [31:0] rk_r [RK_DEPTH];
  logic [9:0]  cnt_r;            // table index
  logic [7:0]  idx_r;            // running shuffle index
  logic [7:0]  ti_r;             // swap temporary
  logic [1:0]  op_r;
  logic [31:0] l_r, r_r;
  logic [4:0]  rnd_r;            // rounds left
  logic [3:0]  ki_r;             // current round key
  logic [3:0]  step_r;           // step within a round
  logic [7:0]  v_r, x_r, y_r, z_r;
  logic        v9_r;
  logic        out_valid_r;
  logic [31:0] lo_r, ro_r;

  logic              t_we;
  logic [TBL_AW-1:0] t_addr;
  logic [7:0]        t_wdata, t_rdata;

  ksfc_ram #(.WIDTH(8), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
  );

  logic [4:0] n_rounds;
  assign n_rounds = (round_count_r > 5'(MAX_ROUNDS)) ? 5'(MAX_ROUNDS) : round_count_r;

  logic [7:0] kbyte;
  always_comb begin
    logic [63:0] w;
    w = cnt_r[3] ? key_low_r : key_high_r;
    kbyte = w[8*(7-cnt_r[2:0]) +: 8];
  end

  logic [31:0] ksum;
  always_comb begin
    logic [31:0] w [4];
    w[0] = key_high_r[63:32]; w[1] = key_high_r[31:0];
    w[2] = key_low_r[63:32];  w[3] = key_low_r[31:0];
    if (IV_WORDS > 0) w[0] = w[0] ^ iv_high_r[63:32];
    if (IV_WORDS > 1) w[1] = w[1] ^ iv_high_r[31:0];
    if (IV_WORDS > 2) w[2] = w[2] ^ iv_low_r[63:32];
    if (IV_WORDS > 3) w[3] = w[3] ^ iv_low_r[31:0];
    ksum = w[0] + w[1] + w[2] + w[3];
  end

  logic [7:0] j_nxt;
  assign j_nxt = idx_r + kbyte;

  logic busy;
  assign busy = (state_r != ST_IDLE);
  assign in_ch.ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign cfg_ch.ready = !busy;
  assign out_ch.valid = out_valid_r;
  assign out_ch.left_out  = lo_r;
  assign out_ch.right_out = ro_r;

  // table port drive for clear, fill and swap; round steps: address issued at step k, data back at k+1
  always_comb begin
    t_we = 1'b0; t_addr = '0; t_wdata = '0;
    case (state_r)
      ST_CLR:  begin t_we = 1'b1; t_addr = cnt_r[9:0]; t_wdata = '0; end
      ST_INIT: begin t_we = 1'b1; t_addr = cnt_r[9:0]; t_wdata = cnt_r[7:0]; end
      ST_SWRI: t_addr = cnt_r[9:0];
      ST_SWRJ: t_addr = {cnt_r[9:8], idx_r};
      ST_SWWI: begin t_we = 1'b1; t_addr = cnt_r[9:0]; t_wdata = t_rdata; end
      ST_SWWJ: begin t_we = 1'b1; t_addr = {cnt_r[9:8], idx_r}; t_wdata = ti_r; end
      ST_RND: begin
        case (step_r)
          4'd0: t_addr = {2'd0, v_r};
          4'd1: t_addr = {2'd1, x_r};
          4'd2: t_addr = {2'd2, y_r};
          4'd3: t_addr = {2'd3, z_r};
          4'd5: t_addr = {2'd1, z_r};
          4'd6: t_addr = {2'd2, v_r};
          4'd7: t_addr = {2'd2, y_r};
          4'd9: t_addr = {2'd3, x_r};
          4'd11: t_addr = {1'b0, v9_r, v_r};
          default: t_addr = '0;
        endcase
      end
      default: ;
    endcase
  end

  logic [7:0] s1z_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR; cnt_r <= '0; out_valid_r <= 1'b0;
      key_high_r <= '0; key_low_r <= '0; iv_high_r <= '0; iv_low_r <= '0;
      round_count_r <= 5'd16;
      for (int k = 0; k < RK_DEPTH; k++) rk_r[k] <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_KEY_HIGH:    key_high_r <= cfg_ch.data;
          REG_KEY_LOW:     key_low_r <= cfg_ch.data;
          REG_IV_HIGH:     iv_high_r <= cfg_ch.data;
          REG_IV_LOW:      iv_low_r <= cfg_ch.data;
          REG_ROUND_COUNT: round_count_r <= cfg_ch.data[4:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_CLR: begin
          cnt_r <= cnt_r + 10'd1;
          if (cnt_r == 10'(TBL_DEPTH - 1)) begin state_r <= ST_IDLE; end
        end
        ST_IDLE: if (in_ch.valid && !out_valid_r) begin
          op_r <= in_ch.op; l_r <= in_ch.left_in;
          cnt_r <= '0; idx_r <= '0; step_r <= '0;
          rnd_r <= n_rounds;
          ki_r <= (in_ch.op == OP_DECRYPT) ? 4'(n_rounds - 5'd1) : 4'd0;
          case (op_t'(in_ch.op))
            OP_REKEY: state_r <= ST_INIT;
            OP_ENCRYPT, OP_DECRYPT: begin
              if (n_rounds == 5'd0) begin
                // no rounds: only the final swap remains
                lo_r <= in_ch.right_in; ro_r <= in_ch.left_in;
                out_valid_r <= 1'b1;
              end else begin
                state_r <= ST_RND;
                if (in_ch.op == OP_ENCRYPT) begin
                  r_r <= in_ch.right_in ^ rk_r[0];
                  {v_r, x_r, y_r, z_r} <= in_ch.right_in ^ rk_r[0];
                end else begin
                  r_r <= in_ch.right_in;
                  {v_r, x_r, y_r, z_r} <= in_ch.right_in;
                end
              end
            end
            default: begin lo_r <= '0; ro_r <= '0; out_valid_r <= 1'b1; end
          endcase
        end
        ST_INIT: begin
          cnt_r <= cnt_r + 10'd1;
          if (cnt_r == 10'(TBL_DEPTH - 1)) begin
            state_r <= ST_SWRI;
            for (int k = 0; k < RK_DEPTH; k++)
              if (5'(k) < n_rounds) rk_r[k] <= ksum * 32'(k + 2) + 32'd1;
          end
        end
        ST_SWRI: begin idx_r <= j_nxt; state_r <= ST_SWRJ; end
        ST_SWRJ: begin ti_r <= t_rdata; state_r <= ST_SWWI; end
        ST_SWWI: state_r <= ST_SWWJ;
        ST_SWWJ: begin
          cnt_r <= cnt_r + 10'd1;
          if (cnt_r == 10'(TBL_DEPTH - 1)) begin
            state_r <= ST_DONE; lo_r <= '0; ro_r <= '0;
          end else state_r <= ST_SWRI;
        end
        ST_RND: begin
          step_r <= (step_r == 4'd13) ? 4'd0 : step_r + 4'd1;
          case (step_r)
            4'd1: v_r <= v_r ^ t_rdata;
            4'd2: x_r <= x_r ^ t_rdata;
            4'd3: y_r <= y_r ^ t_rdata;
            4'd4: z_r <= z_r ^ t_rdata;
            4'd6: s1z_r <= t_rdata;
            4'd7: {v9_r, v_r} <= {1'b0, v_r} ^ ({1'b0, s1z_r} + {1'b0, t_rdata});
            4'd8: x_r <= x_r ^ t_rdata;
            4'd10: y_r <= y_r ^ t_rdata;
            4'd12: z_r <= z_r ^ t_rdata;
            4'd13: begin
              rnd_r <= rnd_r - 5'd1;
              if (op_r == OP_ENCRYPT) begin
                l_r <= r_r;
                r_r <= l_r ^ {v_r, x_r, y_r, z_r} ^ rk_r[4'(ki_r + 4'd1)];
                {v_r, x_r, y_r, z_r} <= l_r ^ {v_r, x_r, y_r, z_r} ^ rk_r[4'(ki_r + 4'd1)];
                ki_r <= ki_r + 4'd1;
                if (rnd_r == 5'd1) begin
                  lo_r <= l_r ^ {v_r, x_r, y_r, z_r}; ro_r <= r_r;
                  state_r <= ST_DONE;
                end
              end else begin
                l_r <= r_r ^ rk_r[ki_r];
                r_r <= l_r ^ {v_r, x_r, y_r, z_r};
                {v_r, x_r, y_r, z_r} <= l_r ^ {v_r, x_r, y_r, z_r};
                ki_r <= ki_r - 4'd1;
                if (rnd_r == 5'd1) begin
                  lo_r <= l_r ^ {v_r, x_r, y_r, z_r}; ro_r <= r_r ^ rk_r[ki_r];
                  state_r <= ST_DONE;
                end
              end
            end
            default: ;
          endcase
        end
        ST_DONE: begin out_valid_r <= 1'b1; state_r <= ST_IDLE; end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // no item is taken while the block works or a word still waits
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!busy && !out_valid_r)) else $error("ready while busy");
  // a result word appears only after the done step or directly from idle
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE || $past(state_r) == ST_IDLE))
    else $error("result from wrong state");
  // the round step counter never runs past the last step
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= 4'd13 || state_r != ST_RND) else $error("round step overrun");
  // a pending word holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(lo_r)))
    else $error("result dropped");
endmodule
`default_nettype wire

// File: hw/rtl/ksfc_ram.sv
// generic single-port ram with registered read
`default_nettype none
module ksfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: tb/ksfc_tb_scoreboard.sv
// scoreboard class: predicts cipher results and checks the result channel
class ksfc_scoreboard;
  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic [4:0]  round_count;
  logic [7:0]  sbox[1024];
  logic [31:0] rkey[16];
  logic [63:0] expected_words[$];
  int          errors;

  function new();
    key_high = 0; key_low = 0; iv_high = 0; iv_low = 0;
    round_count = 5'd16;
    foreach (sbox[i]) sbox[i] = 8'h00;
    foreach (rkey[i]) rkey[i] = 32'h0;
    errors = 0;
  endfunction

  function void write_reg(ksfc_pkg::reg_idx_t idx, logic [63:0] d);
    case (idx)
      ksfc_pkg::REG_KEY_HIGH:    key_high = d;
      ksfc_pkg::REG_KEY_LOW:     key_low = d;
      ksfc_pkg::REG_IV_HIGH:     iv_high = d;
      ksfc_pkg::REG_IV_LOW:      iv_low = d;
      ksfc_pkg::REG_ROUND_COUNT: round_count = d[4:0];
      default: ;
    endcase
  endfunction

  function int unsigned rounds();
    return (round_count > 16) ? 16 : round_count;
  endfunction

  function void rebuild_state();
    logic [127:0] key, iv;
    logic [7:0]   j, t;
    logic [31:0]  w, sum, acc;
    key = {key_high, key_low};
    iv = {iv_high, iv_low};
    for (int i = 0; i < 1024; i++) sbox[i] = i[7:0];
    j = 0;
    for (int s = 0; s < 4; s++)
      for (int i = 0; i < 256; i++) begin
        j = j + key[127 - 8*(i%16) -: 8];
        t = sbox[s*256 + i];
        sbox[s*256 + i] = sbox[s*256 + j];
        sbox[s*256 + j] = t;
      end
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      w = key[127 - 32*k -: 32];
      if (k < 4) w = w ^ iv[127 - 32*k -: 32];
      sum = sum + w;
    end
    acc = sum + 1;
    for (int i = 0; i < rounds(); i++) begin
      acc = acc + sum;
      rkey[i] = acc;
    end
  endfunction

  function logic [31:0] mix(logic [31:0] r);
    logic [8:0] v;
    logic [7:0] x, y, z;
    v = {1'b0, r[31:24]}; x = r[23:16]; y = r[15:8]; z = r[7:0];
    v = v ^ sbox[v];
    x = x ^ sbox[256 + x];
    y = y ^ sbox[512 + y];
    z = z ^ sbox[768 + z];
    v = v ^ ({1'b0, sbox[256 + z]} + {1'b0, sbox[512 + v[7:0]]});
    x = x ^ sbox[512 + y];
    y = y ^ sbox[768 + x];
    z = z ^ sbox[v];
    return {v[7:0], x, y, z};
  endfunction

  function void note_input(ksfc_pkg::op_t op, logic [31:0] l, logic [31:0] r);
    logic [31:0] t;
    int n;
    n = rounds();
    case (op)
      ksfc_pkg::OP_REKEY: begin
        rebuild_state();
        expected_words.push_back(64'h0);
      end
      ksfc_pkg::OP_ENCRYPT: begin
        for (int i = 0; i < n; i++) begin
          r = r ^ rkey[i];
          l = l ^ mix(r);
          t = l; l = r; r = t;
        end
        expected_words.push_back({r, l});
      end
      ksfc_pkg::OP_DECRYPT: begin
        for (int i = n; i > 0; i--) begin
          l = l ^ mix(r);
          r = r ^ rkey[i-1];
          t = l; l = r; r = t;
        end
        expected_words.push_back({r, l});
      end
      default: expected_words.push_back(64'h0);
    endcase
  endfunction

  function void check_result(logic [31:0] l, logic [31:0] r);
    logic [63:0] e;
    if (expected_words.size() == 0) begin
      $error("unexpected word left_out=%h right_out=%h", l, r);
      errors++;
      return;
    end
    e = expected_words.pop_front();
    if (l !== e[63:32]) begin
      $error("left_out expected %h actual %h", e[63:32], l);
      errors++;
    end
    if (r !== e[31:0]) begin
      $error("right_out expected %h actual %h", e[31:0], r);
      errors++;
    end
  endfunction
endclass

// File: tb/keyed_sbox_feistel_cipher_unit_tb.sv
// testbench top: drives the cipher unit and checks its results
module keyed_sbox_feistel_cipher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ksfc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  ksfc_in_if  in_ch();
  ksfc_out_if out_ch();
  ksfc_cfg_if cfg_ch();
  ksfc_scoreboard cipher_sb = new();
  bit stim_done = 0;

  keyed_sbox_feistel_cipher_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 0; in_ch.op = OP_REKEY; in_ch.left_in = 0; in_ch.right_in = 0;
    cfg_ch.valid = 0; cfg_ch.index = REG_KEY_HIGH; cfg_ch.data = 0;
    out_ch.ready = 0;
  end

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [63:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cipher_sb.write_reg(idx, d);
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  // burst mode skips gaps so valid stays high across words
  task automatic send_word(op_t op, logic [31:0] l, logic [31:0] r, bit burst);
    if (!burst) begin
      // a word left up by a burst must drop before the gap
      if (in_ch.valid) begin
        @(negedge clk);
        in_ch.valid <= 0;
      end
      repeat (gap_len()) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1; in_ch.op <= op; in_ch.left_in <= l; in_ch.right_in <= r;
    do @(posedge clk); while (!in_ch.ready);
    cipher_sb.note_input(op, l, r);
    if (!burst) begin
      @(negedge clk);
      in_ch.valid <= 0;
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    in_ch.valid <= 0;
    while (cipher_sb.expected_words.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  always @(posedge clk)
    if (rst_n && out_ch.valid && out_ch.ready)
      cipher_sb.check_result(out_ch.left_out, out_ch.right_out);

  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = (!stim_done && $urandom_range(0, 9) < 3) ? gap_len() : 0;
      if (stall > 0) begin
        out_ch.ready <= 0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1;
    end
  end

  function op_t rand_op();
    int p;
    p = $urandom_range(0, 99);
    if (p < 4) return OP_REKEY;
    if (p < 6) return OP_NONE;
    return (p < 53) ? OP_ENCRYPT : OP_DECRYPT;
  endfunction

  task automatic setup_phase(logic [4:0] rc, bit zero_keys, bit ones_keys);
    logic [63:0] v[4];
    foreach (v[k]) v[k] = zero_keys ? 64'h0 : ones_keys ? '1 : {$urandom, $urandom};
    write_reg(REG_KEY_HIGH, v[0]);
    write_reg(REG_KEY_LOW, v[1]);
    write_reg(REG_IV_HIGH, v[2]);
    write_reg(REG_IV_LOW, v[3]);
    write_reg(REG_ROUND_COUNT, {59'h0, rc});
  endtask

  initial begin
    logic [31:0] l, r;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // directed: before rekey, zero state, unused op, extremes
    send_word(OP_ENCRYPT, 32'h0, 32'hFFFFFFFF, 0);
    send_word(OP_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    send_word(OP_REKEY, 32'h12345678, 32'h9ABCDEF0, 0);
    send_word(OP_DECRYPT, 32'hFFFFFFFF, 32'h0, 0);
    drain();
    setup_phase(5'd16, 0, 1);
    send_word(OP_REKEY, 0, 0, 0);
    send_word(OP_ENCRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    send_word(OP_DECRYPT, 32'h0, 32'h0, 0);
    send_word(OP_ENCRYPT, 32'h80000000, 32'h00000001, 0);
    drain();
    // round count above max, zero, and one; rekey keeps old high round keys
    setup_phase(5'd31, 0, 0);
    send_word(OP_REKEY, 0, 0, 0);
    send_word(OP_ENCRYPT, 32'hDEADBEEF, 32'h01234567, 0);
    drain();
    write_reg(REG_ROUND_COUNT, 64'd0);
    send_word(OP_ENCRYPT, 32'hA5A5A5A5, 32'h5A5A5A5A, 0);
    send_word(OP_REKEY, 0, 0, 0);
    send_word(OP_DECRYPT, 32'h11111111, 32'h22222222, 0);
    drain();
    write_reg(REG_ROUND_COUNT, 64'd16);
    send_word(OP_ENCRYPT, 32'h33333333, 32'h44444444, 0);
    drain();
    setup_phase(5'd1, 1, 0);
    send_word(OP_REKEY, 0, 0, 0);
    send_word(OP_ENCRYPT, 32'hFFFF0000, 32'h0000FFFF, 0);
    send_word(OP_DECRYPT, 32'hFFFF0000, 32'h0000FFFF, 0);
    drain();
    // random phases with varied settings, each starting with a rekey
    for (int ph = 0; ph < 11; ph++) begin
      logic [4:0] rc;
      int burst_run;
      rc = (ph % 4 == 0) ? 5'd16 : (ph % 4 == 1) ? 5'd1 : 5'($urandom_range(0, 31));
      setup_phase(rc, 0, 0);
      send_word(OP_REKEY, $urandom, $urandom, 0);
      burst_run = 0;
      for (int k = 0; k < 100; k++) begin
        op_t op;
        op = rand_op();
        l = $urandom; r = $urandom;
        if ($urandom_range(0, 9) == 0) l = $urandom_range(0, 1) ? 32'h0 : '1;
        if ($urandom_range(0, 9) == 0) r = $urandom_range(0, 1) ? 32'h0 : '1;
        if (burst_run == 0 && $urandom_range(0, 9) == 0) burst_run = $urandom_range(3, 12);
        send_word(op, l, r, burst_run > 0);
        if (burst_run > 0) burst_run--;
      end
      drain();
    end
    stim_done = 1;
    drain();
    if (cipher_sb.errors == 0 && cipher_sb.expected_words.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/ksfc_pkg.sv
hw/rtl/ksfc_if.sv
hw/rtl/ksfc_ram.sv
hw/rtl/keyed_sbox_feistel_cipher_unit.sv
tb/ksfc_tb_scoreboard.sv
tb/keyed_sbox_feistel_cipher_unit_tb.sv
